### rtl/vmm_pkg.sv
// Shared types, constants and helpers for the video memory map.
`default_nettype none
package vmm_pkg;

    // Name table size in bytes; a power of two between 256 and 1024.
    localparam int TABLE_BYTES     = 1024;
    localparam int PALETTE_ENTRIES = 32;
    localparam int NUM_TABLES      = 4;

    localparam int NT_AW  = $clog2(TABLE_BYTES);
    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    localparam int ADDR_W     = 16;
    localparam int BUS_AW     = 14;
    localparam int PAT_AW     = 13;
    localparam int DATA_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic [BUS_AW-1:0] ADDR_NT_BASE  = 14'h2000;
    localparam logic [BUS_AW-1:0] ADDR_PAL_BASE = 14'h3F00;

    typedef enum logic [1:0] {
        MIR_HORIZONTAL = 2'd0,
        MIR_VERTICAL   = 2'd1,
        MIR_SINGLE     = 2'd2,
        MIR_FOUR       = 2'd3
    } t_mirror_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIRROR_MODE    = 1'd0,
        CFG_PATTERN_IS_RAM = 1'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REG_PATTERN   = 2'd0,
        REG_NAMETABLE = 2'd1,
        REG_PALETTE   = 2'd2
    } t_region;

    // Item held while its memory read completes.
    typedef struct packed {
        logic              rd;
        t_region           region;
        logic [1:0]        bank;
        logic              pacc;
        logic              pwr;
        logic [PAT_AW-1:0] paddr;
        logic [DATA_W-1:0] pdata;
    } t_stage;

    // Byte offset within a table.
    function automatic logic [NT_AW-1:0] nt_ofs(input logic [9:0] a);
        logic [31:0] t;
        t = 32'(a) % TABLE_BYTES;
        return t[NT_AW-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/vmm_in_if.sv
// Access channel: command, bus address and write byte.
`default_nettype none
interface vmm_in_if;
    import vmm_pkg::*;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;

    modport source (output valid, cmd, addr, wdata, input ready);
    modport sink (input valid, cmd, addr, wdata, output ready);
endinterface
`default_nettype wire

### rtl/vmm_out_if.sv
// Result channel: read byte and pattern port signals.
`default_nettype none
interface vmm_out_if;
    import vmm_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              pattern_access;
    logic              pattern_write;
    logic [PAT_AW-1:0] pattern_addr;
    logic [DATA_W-1:0] pattern_data;

    modport source (output valid, read_data, pattern_access, pattern_write,
                    pattern_addr, pattern_data, input ready);
    modport sink (input valid, read_data, pattern_access, pattern_write,
                  pattern_addr, pattern_data, output ready);
endinterface
`default_nettype wire

### rtl/vmm_ram.sv
// Single-port synchronous RAM with registered read data.
`default_nettype none
module vmm_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/video_memory_map_with_mirroring.sv
// Video bus memory map: four mirrored name tables, palette, pattern port.
// An accepted item is held in the s1 stage register, then in the output register;
// read data is taken from the registered RAM output into the output register.
// Throughput: one item per cycle while results are taken; each single-port RAM
// takes one access a cycle, and a stalled result holds the input off once s1 is full.
// Reset: clears pipeline valids and config (horizontal mirroring, pattern ROM);
// RAM contents stay undefined until written, with no clearing pass.
`default_nettype none
module video_memory_map_with_mirroring
    import vmm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    vmm_in_if.sink                     i_item,
    vmm_out_if.source                  o_result
);

    t_mirror_mode r_mirror_mode;
    logic         r_pattern_is_ram;

    logic              r_s1_valid;
    t_stage            r_s1;
    t_stage            n_s1;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_rdata;
    logic [DATA_W-1:0] n_out_rdata;
    logic              r_out_pacc;
    logic              r_out_pwr;
    logic [PAT_AW-1:0] r_out_paddr;
    logic [DATA_W-1:0] r_out_pdata;

    logic                  acc;
    logic                  s1_adv;
    logic [BUS_AW-1:0]     a;
    t_region               region;
    logic [1:0]            tbl;
    logic [NUM_TABLES-1:0] nt_hit;
    logic [NUM_TABLES-1:0] nt_en;
    logic [NT_AW-1:0]      nt_addr;
    logic [DATA_W-1:0]     nt_dout [NUM_TABLES];
    logic [PAL_AW-1:0]     pal_idx;
    logic [PAL_AW-1:0]     pal_addr;
    logic                  pal_en;
    logic                  pal_wok;
    logic [DATA_W-1:0]     pal_dout;

    assign s1_adv       = !r_out_valid || o_result.ready;
    assign i_item.ready = !r_s1_valid || s1_adv;
    assign acc          = i_item.valid && i_item.ready;

    // Decode
    always_comb begin
        a   = i_item.addr[BUS_AW-1:0];
        tbl = a[11:10];   // 0x3000 mirror keeps the table bits
        if (a < ADDR_NT_BASE) begin
            region = REG_PATTERN;
        end else if (a < ADDR_PAL_BASE) begin
            region = REG_NAMETABLE;
        end else begin
            region = REG_PALETTE;
        end

        for (int t = 0; t < NUM_TABLES; t++) begin
            nt_hit[t] = (2'(t) == tbl)
                || (r_mirror_mode == MIR_HORIZONTAL && 2'(t) == (tbl ^ 2'd1))
                || (r_mirror_mode == MIR_VERTICAL && 2'(t) == (tbl ^ 2'd2))
                || (r_mirror_mode == MIR_SINGLE);
            nt_en[t] = acc && region == REG_NAMETABLE && (!i_item.cmd || nt_hit[t]);
        end
        nt_addr = nt_ofs(a[9:0]);

        // Multiple-of-four entries share one location; only 0 and 0x10 write it.
        pal_idx  = a[PAL_AW-1:0];
        pal_addr = (pal_idx[1:0] == 2'd0) ? '0 : pal_idx;
        pal_wok  = (pal_idx[1:0] != 2'd0) || (pal_idx[3:2] == 2'd0);
        pal_en   = acc && region == REG_PALETTE && (!i_item.cmd || pal_wok);

        n_s1.rd     = !i_item.cmd && region != REG_PATTERN;
        n_s1.region = region;
        n_s1.bank   = tbl;
        n_s1.pacc   = region == REG_PATTERN;
        n_s1.pwr    = region == REG_PATTERN && i_item.cmd && r_pattern_is_ram;
        n_s1.paddr  = (region == REG_PATTERN) ? a[PAT_AW-1:0] : '0;
        n_s1.pdata  = n_s1.pwr ? i_item.wdata : '0;
    end

    for (genvar g = 0; g < NUM_TABLES; g++) begin : g_nt
        vmm_ram #(
            .DEPTH(TABLE_BYTES),
            .WIDTH(DATA_W)
        ) u_nt_ram (
            .i_clk  (i_clk),
            .i_en   (nt_en[g]),
            .i_we   (i_item.cmd),
            .i_addr (nt_addr),
            .i_wdata(i_item.wdata),
            .o_rdata(nt_dout[g])
        );
    end

    vmm_ram #(
        .DEPTH(PALETTE_ENTRIES),
        .WIDTH(DATA_W)
    ) u_pal_ram (
        .i_clk  (i_clk),
        .i_en   (pal_en),
        .i_we   (i_item.cmd),
        .i_addr (pal_addr),
        .i_wdata(i_item.wdata),
        .o_rdata(pal_dout)
    );

    always_comb begin
        if (!r_s1.rd) begin
            n_out_rdata = '0;
        end else if (r_s1.region == REG_PALETTE) begin
            n_out_rdata = pal_dout;
        end else begin
            n_out_rdata = nt_dout[r_s1.bank];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror_mode    <= MIR_HORIZONTAL;
            r_pattern_is_ram <= 1'b0;
            r_s1_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MIRROR_MODE:    r_mirror_mode    <= t_mirror_mode'(i_cfg_data[1:0]);
                    CFG_PATTERN_IS_RAM: r_pattern_is_ram <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_item.ready) begin
                r_s1_valid <= i_item.valid;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= n_s1;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_rdata <= n_out_rdata;
            r_out_pacc  <= r_s1.pacc;
            r_out_pwr   <= r_s1.pwr;
            r_out_paddr <= r_s1.paddr;
            r_out_pdata <= r_s1.pdata;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.read_data      = r_out_rdata;
    assign o_result.pattern_access = r_out_pacc;
    assign o_result.pattern_write  = r_out_pwr;
    assign o_result.pattern_addr   = r_out_paddr;
    assign o_result.pattern_data   = r_out_pdata;

    a_pwr_needs_pacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_pwr |-> r_out_pacc)
        else $error("pattern write outside pattern space");

    a_pattern_no_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_pacc |-> r_out_rdata == '0)
        else $error("read data on pattern access");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !o_result.ready |-> !i_item.ready)
        else $error("item accepted while pipeline full");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !r_out_valid |=> r_out_valid)
        else $error("held item not moved to output");

endmodule
`default_nettype wire

### tb/tb_video_memory_map_with_mirroring.sv
// Self-checking testbench for the video memory map: name tables, palette and pattern port.
`timescale 1ns / 1ps
module tb_video_memory_map_with_mirroring;
    import vmm_pkg::*;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [BUS_AW-1:0] ADDR_NT_MIRROR     = 14'h3000;
    localparam logic [BUS_AW-1:0] ADDR_MIRROR_OFFSET = 14'h1000;
    localparam int PAL_BACKDROP        = 0;
    localparam int PAL_SPRITE_BACKDROP = 16;

    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int DRAIN_CYCLES    = 6;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_vram_access;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              pattern_access;
        logic              pattern_write;
        logic [PAT_AW-1:0] pattern_addr;
        logic [DATA_W-1:0] pattern_data;
    } t_vram_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    vmm_in_if  in_if ();
    vmm_out_if out_if ();

    video_memory_map_with_mirroring u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (in_if),
        .o_result   (out_if)
    );

    // Shadow of the video memory and the registers
    logic [DATA_W-1:0] nt_mem      [NUM_TABLES*TABLE_BYTES];
    bit                nt_written  [NUM_TABLES*TABLE_BYTES];
    logic [DATA_W-1:0] pal_mem     [PALETTE_ENTRIES];
    bit                pal_written [PALETTE_ENTRIES];
    t_mirror_mode      cfg_mode;
    bit                cfg_pat_ram;

    t_vram_access pending_accesses[$];
    t_vram_result expected_results[$];

    int  cycle_cnt;
    int  launch_cnt;
    int  accept_cnt;
    int  read_cnt;
    int  write_cnt;
    int  checked_cnt;
    int  fail_cnt;
    int  settings_cnt;
    int  send_gap;
    int  ready_stall;
    bit  quiet;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one; none at all in quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit entry_known(input logic [ADDR_W-1:0] addr);
        logic [BUS_AW-1:0] a;
        logic [BUS_AW-1:0] m;
        a = addr[BUS_AW-1:0];
        if (a < ADDR_NT_BASE)
            return 1'b1;
        if (a < ADDR_PAL_BASE) begin
            m = (a >= ADDR_NT_MIRROR) ? a - ADDR_MIRROR_OFFSET : a;
            return nt_written[int'(m[11:10]) * TABLE_BYTES + int'(m[9:0]) % TABLE_BYTES];
        end
        return pal_written[int'(a - ADDR_PAL_BASE) % PALETTE_ENTRIES];
    endfunction

    // Works out the response of one access and applies its write to the shadow
    function automatic t_vram_result vram_predict(input t_vram_access acc);
        t_vram_result      res;
        logic [BUS_AW-1:0] a;
        logic [BUS_AW-1:0] m;
        int                tbl;
        int                ofs;
        int                idx;
        bit                hit;
        res = '0;
        a   = acc.addr[BUS_AW-1:0];
        if (a < ADDR_NT_BASE) begin
            res.pattern_access = 1'b1;
            res.pattern_addr   = a[PAT_AW-1:0];
            if (acc.cmd == CMD_WRITE && cfg_pat_ram) begin
                res.pattern_write = 1'b1;
                res.pattern_data  = acc.wdata;
            end
        end else if (a < ADDR_PAL_BASE) begin
            m   = (a >= ADDR_NT_MIRROR) ? a - ADDR_MIRROR_OFFSET : a;
            tbl = int'(m[11:10]);
            ofs = int'(m[9:0]) % TABLE_BYTES;
            if (acc.cmd == CMD_WRITE) begin
                for (int t = 0; t < NUM_TABLES; t++) begin
                    hit = (t == tbl)
                        || (cfg_mode == MIR_HORIZONTAL && t == (tbl ^ 1))
                        || (cfg_mode == MIR_VERTICAL && t == (tbl ^ 2))
                        || (cfg_mode == MIR_SINGLE);
                    if (hit) begin
                        nt_mem[t * TABLE_BYTES + ofs]     = acc.wdata;
                        nt_written[t * TABLE_BYTES + ofs] = 1'b1;
                    end
                end
            end else begin
                res.read_data = nt_mem[tbl * TABLE_BYTES + ofs];
            end
        end else begin
            idx = int'(a - ADDR_PAL_BASE) % PALETTE_ENTRIES;
            if (acc.cmd == CMD_WRITE) begin
                // backdrop entries fan out to every fourth entry; the others of those are dead
                if (idx == PAL_BACKDROP || idx == PAL_SPRITE_BACKDROP) begin
                    for (int k = 0; k < PALETTE_ENTRIES; k += 4) begin
                        pal_mem[k]     = acc.wdata;
                        pal_written[k] = 1'b1;
                    end
                end else if (idx % 4 != 0) begin
                    pal_mem[idx]     = acc.wdata;
                    pal_written[idx] = 1'b1;
                end
            end else begin
                res.read_data = pal_mem[idx];
            end
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] random_addr();
        logic [BUS_AW-1:0] a;
        logic [1:0]        tbl;
        logic [9:0]        ofs;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            a = 14'($urandom_range(0, 16'h1FFF));
        end else if (pick < 75) begin
            tbl = 2'($urandom_range(0, 3));
            // mostly a small window so reads land on written bytes
            ofs = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                               : 10'($urandom_range(0, 15));
            a = ADDR_NT_BASE + {2'b00, tbl, ofs};
            if ($urandom_range(0, 1) == 1 && (tbl != 2'd3 || ofs < 10'h300))
                a = a + ADDR_MIRROR_OFFSET;
        end else begin
            a = ADDR_PAL_BASE + 14'($urandom_range(0, 255));
        end
        return {2'($urandom_range(0, 3)), a};
    endfunction

    // Mid-cycle, clear of both clock edges
    task automatic mid_cycle();
        @(posedge i_clk);
        #0.5;
    endtask

    task automatic queue_access(input logic cmd, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] wdata);
        t_vram_access acc;
        while (pending_accesses.size() >= 3)
            mid_cycle();
        acc.cmd   = cmd;
        acc.addr  = addr;
        acc.wdata = wdata;
        pending_accesses.push_back(acc);
    endtask

    task automatic random_access();
        logic              cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
        int                tries;
        cmd   = 1'($urandom_range(0, 1));
        wdata = 8'($urandom_range(0, 255));
        addr  = random_addr();
        if (cmd == CMD_READ) begin
            tries = 0;
            while (!entry_known(addr) && tries < 8) begin
                addr = random_addr();
                tries++;
            end
            if (!entry_known(addr))
                cmd = CMD_WRITE;
        end
        queue_access(cmd, addr, wdata);
    endtask

    task automatic drain();
        while (pending_accesses.size() != 0 || expected_results.size() != 0)
            mid_cycle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MIRROR_MODE)
            cfg_mode = t_mirror_mode'(val);
        else
            cfg_pat_ram = val[0];
    endtask

    task automatic apply_setting(input t_mirror_mode mode, input bit pat_ram);
        drain();
        write_reg(CFG_MIRROR_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_PATTERN_IS_RAM, CFG_DATA_W'(pat_ram));
        settings_cnt++;
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 64 == 0)
            quiet <= ($urandom_range(0, 3) == 0);
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sender: holds an item until taken, then waits out a random gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || accept_cnt == launch_cnt) begin
            if (send_gap > 0) begin
                in_if.valid <= 1'b0;
                send_gap--;
            end else if (pending_accesses.size() > 0) begin
                in_if.valid <= 1'b1;
                in_if.cmd   <= pending_accesses[0].cmd;
                in_if.addr  <= pending_accesses[0].addr;
                in_if.wdata <= pending_accesses[0].wdata;
                launch_cnt++;
                send_gap = pick_gap();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        if (ready_stall > 0) begin
            out_if.ready <= 1'b0;
            ready_stall--;
        end else begin
            out_if.ready <= 1'b1;
            ready_stall = pick_gap();
        end
    end

    // Accepted item: predict its response
    always @(posedge i_clk) begin
        t_vram_access acc;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            acc.cmd   = in_if.cmd;
            acc.addr  = in_if.addr;
            acc.wdata = in_if.wdata;
            expected_results.push_back(vram_predict(acc));
            void'(pending_accesses.pop_front());
            accept_cnt++;
            if (acc.cmd == CMD_WRITE)
                write_cnt++;
            else
                read_cnt++;
        end
    end

    always @(posedge i_clk) begin
        t_vram_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_results.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS)
                    $display("cycle %0d: result with nothing expected: rd=%02h pa=%0b pw=%0b",
                             cycle_cnt, out_if.read_data, out_if.pattern_access,
                             out_if.pattern_write);
            end else begin
                want = expected_results.pop_front();
                checked_cnt++;
                if (out_if.read_data !== want.read_data
                        || out_if.pattern_access !== want.pattern_access
                        || out_if.pattern_write !== want.pattern_write
                        || out_if.pattern_addr !== want.pattern_addr
                        || out_if.pattern_data !== want.pattern_data) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display({"cycle %0d: expected rd=%02h pa=%0b pw=%0b paddr=%04h pd=%02h,",
                                  " got rd=%02h pa=%0b pw=%0b paddr=%04h pd=%02h"},
                                 cycle_cnt, want.read_data, want.pattern_access,
                                 want.pattern_write, want.pattern_addr, want.pattern_data,
                                 out_if.read_data, out_if.pattern_access,
                                 out_if.pattern_write, out_if.pattern_addr,
                                 out_if.pattern_data);
                end
            end
        end
    end

    initial begin
        t_mirror_mode modes[RANDOM_PHASES];
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_MIRROR_MODE;
        i_cfg_data   = '0;
        in_if.valid  = 1'b0;
        in_if.cmd    = CMD_READ;
        in_if.addr   = '0;
        in_if.wdata  = '0;
        out_if.ready = 1'b0;
        cfg_mode     = MIR_HORIZONTAL;
        cfg_pat_ram  = 1'b0;
        cycle_cnt    = 0;
        launch_cnt   = 0;
        accept_cnt   = 0;
        read_cnt     = 0;
        write_cnt    = 0;
        checked_cnt  = 0;
        fail_cnt     = 0;
        settings_cnt = 0;
        send_gap     = 0;
        ready_stall  = 0;
        quiet        = 1'b0;
        modes        = '{MIR_FOUR, MIR_SINGLE, MIR_HORIZONTAL, MIR_VERTICAL, MIR_FOUR};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Horizontal mirroring, pattern ROM
        apply_setting(MIR_HORIZONTAL, 1'b0);
        queue_access(CMD_READ,  16'h0000, 8'h00);
        queue_access(CMD_WRITE, 16'h1FFF, 8'hFF);   // dropped: ROM
        queue_access(CMD_WRITE, 16'h2000, 8'hFF);
        queue_access(CMD_WRITE, 16'h2BFF, 8'h00);
        queue_access(CMD_WRITE, 16'h3EFF, 8'h5A);   // top of the name table mirror
        queue_access(CMD_WRITE, 16'h3F00, 8'h3C);   // backdrop fan-out
        queue_access(CMD_WRITE, 16'h3F04, 8'h99);   // dead palette entry
        queue_access(CMD_WRITE, 16'h7F01, 8'h81);
        queue_access(CMD_WRITE, 16'hFFFF, 8'hC3);
        // hold the sender until the writes have all come back
        drain();
        queue_access(CMD_READ, 16'h2400, 8'h00);
        queue_access(CMD_READ, 16'h2FFF, 8'h00);
        queue_access(CMD_READ, 16'h2AFF, 8'h00);
        queue_access(CMD_READ, 16'h3F1C, 8'h00);
        queue_access(CMD_READ, 16'hBF21, 8'h00);
        queue_access(CMD_READ, 16'h3FFF, 8'h00);

        apply_setting(MIR_VERTICAL, 1'b1);
        queue_access(CMD_WRITE, 16'h1234, 8'hA5);
        queue_access(CMD_WRITE, 16'hC000, 8'h7E);
        queue_access(CMD_WRITE, 16'h2801, 8'h11);
        queue_access(CMD_READ,  16'h3001, 8'h00);

        apply_setting(MIR_SINGLE, 1'b1);
        queue_access(CMD_WRITE, 16'h2555, 8'h22);
        queue_access(CMD_READ,  16'h2D55, 8'h00);

        apply_setting(MIR_FOUR, 1'b1);
        queue_access(CMD_WRITE, 16'h2C00, 8'h33);
        queue_access(CMD_READ,  16'h2C00, 8'h00);
        queue_access(CMD_READ,  16'h2000, 8'h00);
        queue_access(CMD_READ,  16'h1FFF, 8'h00);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_setting(modes[p], (p == RANDOM_PHASES - 1) ? 1'($urandom_range(0, 1))
                                                              : 1'(p % 2));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                random_access();
        end

        drain();
        $display("covered %0d accesses (%0d reads, %0d writes) over %0d register settings",
                 accept_cnt, read_cnt, write_cnt, settings_cnt);
        $display("%0d results checked, %0d mismatches", checked_cnt, fail_cnt);
        if (fail_cnt == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### video_memory_map_with_mirroring.f
rtl/vmm_pkg.sv
rtl/vmm_in_if.sv
rtl/vmm_out_if.sv
rtl/vmm_ram.sv
rtl/video_memory_map_with_mirroring.sv
tb/tb_video_memory_map_with_mirroring.sv
